@@ rtl/bmc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bmc_pkg
// shared widths, item types and the command/status types that join the
// controller and the datapath
// ----------------------------------------------------------------------------
package bmc_pkg;

  localparam int VALUE_BITS   = 32;
  localparam int MOD_BITS     = 16;
  localparam int DIV_BITS     = (VALUE_BITS > 2 * MOD_BITS) ? VALUE_BITS : 2 * MOD_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_BITS);
  localparam int S_BITS       = MOD_BITS + 2;

  typedef struct packed {
    logic [VALUE_BITS-1:0] top_value;
    logic [VALUE_BITS-1:0] choose_value;
    logic [MOD_BITS-1:0]   modulus;
  } in_t;

  typedef struct packed {
    logic [MOD_BITS-1:0] residue;
    logic                invalid;
  } out_t;

  typedef enum logic [5:0] {
    OP_NOP, OP_LOAD, OP_TRY, OP_STRIP, OP_NEXTQ, OP_TAIL,
    OP_LEG_N, OP_LEG_M, OP_LEG_D, OP_LEG_STEP,
    OP_BLK_INIT, OP_BLK_MUL, OP_INC,
    OP_FF_N, OP_FF_M, OP_FF_D, OP_FF_DIVPK, OP_FF_MULPOW, OP_FF_MULI, OP_FF_DIVQ,
    OP_POW_BLK, OP_POW_Q, OP_POW_ACC, OP_POW_SQ,
    OP_R_SET, OP_R_MULPA, OP_R_MULIV,
    OP_INV_F, OP_INV_STEP, OP_INV_FIN,
    OP_CRT_CO, OP_CRT_COMOD, OP_CRT_W, OP_CRT_ADD
  } op_t;

  typedef struct packed {
    logic go;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic m_gt_n;
    logic p_lt2;
    logic qsq_le;
    logic rest_gt1;
    logic divz;
    logic pk_gt1;
    logic x_zero;
    logic i_lt_pk;
    logic j_nz;
    logic qt_zero;
    logic qt_lsb;
    logic i_le_rm;
    logic g1_zero;
  } stat_t;

endpackage
`default_nettype wire

@@ rtl/binomial_mod_composite.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// binomial_mod_composite
// C(n,m) mod p for any modulus p by prime-power factoring and crt
//
//   channel   ports                      handshake
//   input     start, busy, in_data       taken when start & !busy
//   result    out_strobe, out_data       one cycle, cannot be held off
//
// one item at a time; busy is high from the cycle after start until the
// result strobe. time per item is set by the shared divider, which serves
// every modular divide and multiply, times the length of the factorial
// loops, which run up to each prime power of p; an item ends early when
// m exceeds n or p < 2.
// synchronous active-low reset returns to idle.
// ----------------------------------------------------------------------------
module binomial_mod_composite import bmc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_strobe,
  output out_t      out_data
);

  cmd_t  cmd;
  stat_t stat;

  bmc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  bmc_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .stat    (stat),
    .res     (out_data)
  );

endmodule
`default_nettype wire

@@ rtl/bmc_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bmc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bmc_div import bmc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [DIV_BITS-1:0] dividend,
  input  wire logic [MOD_BITS-1:0] divisor,
  output logic                     done,
  output logic [DIV_BITS-1:0]      quot,
  output logic [MOD_BITS-1:0]      rem
);

  logic                    busy_r;
  logic                    done_r;
  logic [DIV_CNT_BITS-1:0] cnt_r;
  logic [DIV_BITS-1:0]     dvd_r;
  logic [MOD_BITS-1:0]     rem_r;
  logic [MOD_BITS-1:0]     dsr_r;
  logic [MOD_BITS:0]       trial;
  logic                    ge;
  logic [MOD_BITS:0]       diff;
  logic [MOD_BITS-1:0]     rem_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[DIV_BITS-1]};
    ge      = trial >= {1'b0, dsr_r};
    diff    = trial - {1'b0, dsr_r};
    rem_nxt = ge ? diff[MOD_BITS-1:0] : trial[MOD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[DIV_BITS-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_BITS'(DIV_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = dvd_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

@@ rtl/bmc_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bmc_datapath
// working registers, multipliers and the shared divider; runs one command
// at a time and reports status back to the controller
// ----------------------------------------------------------------------------
module bmc_datapath import bmc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire in_t  in_data,
  input  wire cmd_t cmd,
  output stat_t     stat,
  output out_t      res
);

  typedef enum logic [2:0] {PH_IDLE, PH_START, PH_DIV, PH_DWAIT, PH_SMUL} ph_t;

  localparam int V = VALUE_BITS;
  localparam int M = MOD_BITS;

  ph_t ph_r;
  op_t op_r;
  logic done_r;

  logic [V-1:0] n_r, m_r, d_r, x_r, e_r, qt_r;
  logic [M-1:0] p_r, rest_r, q_r, pk_r, acc_r, tq_r, blk_r, f_r, i_r, j_r, rm_r;
  logic [M-1:0] pb_r, pa_r, r_r, co_r, iv_r, w_r, g0_r, g1_r, qq_r;
  logic signed [S_BITS-1:0] s0_r, s1_r;
  logic [2*M-1:0] prod_r;
  logic inv_flag_r, divz_r, leg_sub_r;

  logic [M-1:0]        mul_a, mul_b, mod_sel;
  logic [DIV_BITS-1:0] div_dvd;
  logic [M-1:0]        div_dsr;
  logic                div_start, div_done;
  logic [DIV_BITS-1:0] div_quot;
  logic [M-1:0]        div_rem;
  logic [2*M-1:0]      qsq, pkq;
  logic [M:0]          csum, csub, j_inc;
  logic signed [S_BITS-1:0] s_nxt, s0_adj;

  function automatic logic is_mm(op_t op);
    case (op)
      OP_BLK_MUL, OP_POW_ACC, OP_POW_SQ, OP_FF_MULPOW, OP_FF_MULI,
      OP_R_MULPA, OP_R_MULIV, OP_CRT_W, OP_CRT_ADD: is_mm = 1'b1;
      default: is_mm = 1'b0;
    endcase
  endfunction

  function automatic logic is_div(op_t op);
    case (op)
      OP_TRY, OP_FF_DIVPK, OP_FF_DIVQ, OP_LEG_STEP, OP_INV_STEP,
      OP_CRT_CO, OP_CRT_COMOD: is_div = 1'b1;
      default: is_div = 1'b0;
    endcase
  endfunction

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_r)
      OP_BLK_MUL:   begin mul_a = blk_r; mul_b = i_r;  end
      OP_POW_ACC:   begin mul_a = pa_r;  mul_b = pb_r; end
      OP_POW_SQ:    begin mul_a = pb_r;  mul_b = pb_r; end
      OP_FF_MULPOW: begin mul_a = f_r;   mul_b = pa_r; end
      OP_FF_MULI:   begin mul_a = f_r;   mul_b = i_r;  end
      OP_R_MULPA:   begin mul_a = r_r;   mul_b = pa_r; end
      OP_R_MULIV:   begin mul_a = r_r;   mul_b = iv_r; end
      OP_CRT_W:     begin mul_a = co_r;  mul_b = iv_r; end
      OP_CRT_ADD:   begin mul_a = w_r;   mul_b = r_r;  end
      default: ;
    endcase
    mod_sel = (op_r == OP_CRT_W || op_r == OP_CRT_ADD) ? p_r : pk_r;
    div_dvd = DIV_BITS'(prod_r);
    div_dsr = mod_sel;
    case (op_r)
      OP_TRY:       begin div_dvd = DIV_BITS'(rest_r); div_dsr = q_r;  end
      OP_FF_DIVPK:  begin div_dvd = DIV_BITS'(x_r);    div_dsr = pk_r; end
      OP_FF_DIVQ:   begin div_dvd = DIV_BITS'(x_r);    div_dsr = q_r;  end
      OP_LEG_STEP:  begin div_dvd = DIV_BITS'(x_r);    div_dsr = q_r;  end
      OP_INV_STEP:  begin div_dvd = DIV_BITS'(g0_r);   div_dsr = g1_r; end
      OP_CRT_CO:    begin div_dvd = DIV_BITS'(p_r);    div_dsr = pk_r; end
      OP_CRT_COMOD: begin div_dvd = DIV_BITS'(co_r);   div_dsr = pk_r; end
      default: ;
    endcase
    div_start = (ph_r == PH_START && is_div(op_r)) || ph_r == PH_DIV;
    qsq    = q_r * q_r;
    pkq    = pk_r * q_r;
    csum   = {1'b0, acc_r} + {1'b0, div_rem};
    csub   = csum - {1'b0, p_r};
    j_inc  = {1'b0, j_r} + 1'b1;
    s_nxt  = s0_r - ($signed({2'b00, qq_r}) * s1_r);
    s0_adj = s0_r + $signed({2'b00, pk_r});
  end

  bmc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
      op_r   <= OP_NOP;
    end else begin
      done_r <= 1'b0;
      case (ph_r)
        PH_IDLE: begin
          if (cmd.go) begin
            if (cmd.op == OP_LOAD) begin
              n_r        <= in_data.top_value;
              m_r        <= in_data.choose_value;
              p_r        <= in_data.modulus;
              d_r        <= in_data.top_value - in_data.choose_value;
              inv_flag_r <= in_data.choose_value > in_data.top_value;
              acc_r      <= '0;
              rest_r     <= in_data.modulus;
              q_r        <= M'(2);
              pk_r       <= M'(1);
              done_r     <= 1'b1;
            end else begin
              op_r <= cmd.op;
              ph_r <= PH_START;
            end
          end
        end
        PH_START: begin
          if (is_mm(op_r)) begin
            prod_r <= mul_a * mul_b;
            ph_r   <= PH_DIV;
          end else if (is_div(op_r)) begin
            ph_r <= PH_DWAIT;
          end else begin
            case (op_r)
              OP_STRIP:    begin rest_r <= tq_r; pk_r <= pkq[M-1:0]; end
              OP_NEXTQ:    begin q_r <= q_r + 1'b1; pk_r <= M'(1); end
              OP_TAIL:     begin q_r <= rest_r; pk_r <= rest_r; end
              OP_LEG_N:    begin x_r <= n_r; e_r <= '0; leg_sub_r <= 1'b0; end
              OP_LEG_M:    begin x_r <= m_r; leg_sub_r <= 1'b1; end
              OP_LEG_D:    begin x_r <= d_r; leg_sub_r <= 1'b1; end
              OP_BLK_INIT: begin blk_r <= M'(1); i_r <= M'(1); j_r <= M'(1); end
              OP_INC: begin
                i_r <= i_r + 1'b1;
                j_r <= (j_inc == {1'b0, q_r}) ? '0 : j_inc[M-1:0];
              end
              OP_FF_N:     begin x_r <= n_r; f_r <= M'(1); end
              OP_FF_M:     begin x_r <= m_r; f_r <= M'(1); end
              OP_FF_D:     begin x_r <= d_r; f_r <= M'(1); end
              OP_POW_BLK:  begin pb_r <= blk_r; pa_r <= M'(1); end
              OP_POW_Q:    begin pb_r <= q_r; pa_r <= M'(1); qt_r <= e_r; end
              OP_R_SET:    r_r <= f_r;
              OP_INV_F: begin
                g0_r <= pk_r;
                g1_r <= f_r;
                s0_r <= '0;
                s1_r <= S_BITS'(1);
              end
              OP_INV_FIN:  iv_r <= s0_r[S_BITS-1] ? s0_adj[M-1:0] : s0_r[M-1:0];
              default: ;
            endcase
            done_r <= 1'b1;
            ph_r   <= PH_IDLE;
          end
        end
        PH_DIV: ph_r <= PH_DWAIT;
        PH_DWAIT: begin
          if (div_done) begin
            if (op_r == OP_INV_STEP) begin
              ph_r <= PH_SMUL;
            end else begin
              done_r <= 1'b1;
              ph_r   <= PH_IDLE;
            end
            case (op_r)
              OP_BLK_MUL:   blk_r <= div_rem;
              OP_POW_ACC:   pa_r <= div_rem;
              OP_POW_SQ:    begin pb_r <= div_rem; qt_r <= qt_r >> 1; end
              OP_FF_MULPOW: begin f_r <= div_rem; i_r <= M'(1); j_r <= M'(1); end
              OP_FF_MULI:   f_r <= div_rem;
              OP_R_MULPA:   r_r <= div_rem;
              OP_R_MULIV:   r_r <= div_rem;
              OP_CRT_W:     w_r <= div_rem;
              OP_CRT_ADD:   acc_r <= (csum >= {1'b0, p_r}) ? csub[M-1:0] : csum[M-1:0];
              OP_TRY:       begin tq_r <= div_quot[M-1:0]; divz_r <= div_rem == '0; end
              OP_FF_DIVPK:  begin qt_r <= div_quot[V-1:0]; rm_r <= div_rem; end
              OP_FF_DIVQ:   x_r <= div_quot[V-1:0];
              OP_LEG_STEP: begin
                x_r <= div_quot[V-1:0];
                e_r <= leg_sub_r ? e_r - div_quot[V-1:0] : e_r + div_quot[V-1:0];
              end
              OP_INV_STEP: begin
                qq_r <= div_quot[M-1:0];
                g0_r <= g1_r;
                g1_r <= div_rem;
              end
              OP_CRT_CO:    co_r <= div_quot[M-1:0];
              OP_CRT_COMOD: begin
                g0_r <= pk_r;
                g1_r <= div_rem;
                s0_r <= '0;
                s1_r <= S_BITS'(1);
              end
              default: ;
            endcase
          end
        end
        PH_SMUL: begin
          s0_r   <= s1_r;
          s1_r   <= s_nxt;
          done_r <= 1'b1;
          ph_r   <= PH_IDLE;
        end
        default: ph_r <= PH_IDLE;
      endcase
    end
  end

  always_comb begin
    stat.done     = done_r;
    stat.m_gt_n   = inv_flag_r;
    stat.p_lt2    = p_r < M'(2);
    stat.qsq_le   = qsq <= (2*M)'(rest_r);
    stat.rest_gt1 = rest_r > M'(1);
    stat.divz     = divz_r;
    stat.pk_gt1   = pk_r > M'(1);
    stat.x_zero   = x_r == '0;
    stat.i_lt_pk  = i_r < pk_r;
    stat.j_nz     = j_r != '0;
    stat.qt_zero  = qt_r == '0;
    stat.qt_lsb   = qt_r[0];
    stat.i_le_rm  = i_r <= rm_r;
    stat.g1_zero  = g1_r == '0;
    res.residue   = acc_r;
    res.invalid   = inv_flag_r;
  end

endmodule
`default_nettype wire

@@ rtl/bmc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bmc_ctrl
// sequencer: factor loop, legendre sums, factorial residues, powers,
// inverses and the crt join, one datapath command at a time
// ----------------------------------------------------------------------------
module bmc_ctrl import bmc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  input  wire stat_t stat,
  output cmd_t       cmd,
  output logic       busy,
  output logic       out_strobe
);

  typedef enum logic [5:0] {
    S_IDLE, S_LOAD, S_CHKQ, S_TRY, S_STRIP, S_NEXTQ, S_TAIL,
    S_LEGN, S_LEGM, S_LEGD, S_LEGS,
    S_BLKI, S_BLKC, S_BLKM, S_BLKINC,
    S_FFI, S_FFC, S_FFDIV, S_FFMP, S_FFRC, S_FFMI, S_FFINC, S_FFDQ,
    S_POWB, S_POWQ, S_POWC, S_POWA, S_POWS,
    S_RSET, S_RMP, S_RMIV,
    S_INVF, S_INVC, S_INVS, S_INVE,
    S_CRTCO, S_CRTM, S_CRTW, S_CRTA
  } state_t;

  typedef enum logic [1:0] {CX_N, CX_M, CX_D, CX_CRT} ctx_t;

  state_t state_r;
  ctx_t   ctx_r;
  logic   wait_r, strobe_r, powq_r, tail_r;
  op_t    op_s;

  always_comb begin
    case (state_r)
      S_LOAD:   op_s = OP_LOAD;
      S_TRY:    op_s = OP_TRY;
      S_STRIP:  op_s = OP_STRIP;
      S_NEXTQ:  op_s = OP_NEXTQ;
      S_TAIL:   op_s = OP_TAIL;
      S_LEGN:   op_s = OP_LEG_N;
      S_LEGM:   op_s = OP_LEG_M;
      S_LEGD:   op_s = OP_LEG_D;
      S_LEGS:   op_s = OP_LEG_STEP;
      S_BLKI:   op_s = OP_BLK_INIT;
      S_BLKM:   op_s = OP_BLK_MUL;
      S_BLKINC: op_s = OP_INC;
      S_FFI:    op_s = (ctx_r == CX_N) ? OP_FF_N : ((ctx_r == CX_M) ? OP_FF_M : OP_FF_D);
      S_FFDIV:  op_s = OP_FF_DIVPK;
      S_FFMP:   op_s = OP_FF_MULPOW;
      S_FFMI:   op_s = OP_FF_MULI;
      S_FFINC:  op_s = OP_INC;
      S_FFDQ:   op_s = OP_FF_DIVQ;
      S_POWB:   op_s = OP_POW_BLK;
      S_POWQ:   op_s = OP_POW_Q;
      S_POWA:   op_s = OP_POW_ACC;
      S_POWS:   op_s = OP_POW_SQ;
      S_RSET:   op_s = OP_R_SET;
      S_RMP:    op_s = OP_R_MULPA;
      S_RMIV:   op_s = OP_R_MULIV;
      S_INVF:   op_s = OP_INV_F;
      S_INVS:   op_s = OP_INV_STEP;
      S_INVE:   op_s = OP_INV_FIN;
      S_CRTCO:  op_s = OP_CRT_CO;
      S_CRTM:   op_s = OP_CRT_COMOD;
      S_CRTW:   op_s = OP_CRT_W;
      S_CRTA:   op_s = OP_CRT_ADD;
      default:  op_s = OP_NOP;
    endcase
    cmd.go = (state_r == S_IDLE) ? start : !wait_r;
    cmd.op = (state_r == S_IDLE) ? OP_LOAD : op_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ctx_r    <= CX_N;
      wait_r   <= 1'b0;
      strobe_r <= 1'b0;
      powq_r   <= 1'b0;
      tail_r   <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      if (state_r == S_IDLE) begin
        if (start) begin
          state_r <= S_LOAD;
          wait_r  <= 1'b1;
          tail_r  <= 1'b0;
        end
      end else if (!wait_r) begin
        wait_r <= 1'b1;
      end else if (stat.done) begin
        wait_r <= 1'b0;
        case (state_r)
          S_LOAD: begin
            if (stat.m_gt_n || stat.p_lt2) begin
              state_r  <= S_IDLE;
              strobe_r <= 1'b1;
            end else begin
              state_r <= S_CHKQ;
            end
          end
          S_CHKQ: begin
            if (stat.qsq_le) begin
              state_r <= S_TRY;
            end else if (stat.rest_gt1) begin
              state_r <= S_TAIL;
            end else begin
              state_r  <= S_IDLE;
              strobe_r <= 1'b1;
            end
          end
          S_TRY: begin
            if (stat.divz) begin
              state_r <= S_STRIP;
            end else if (stat.pk_gt1) begin
              state_r <= S_LEGN;
            end else begin
              state_r <= S_NEXTQ;
            end
          end
          S_STRIP: state_r <= S_TRY;
          S_NEXTQ: state_r <= S_CHKQ;
          S_TAIL: begin
            tail_r  <= 1'b1;
            state_r <= S_LEGN;
          end
          S_LEGN, S_LEGM, S_LEGD, S_LEGS: begin
            if (!stat.x_zero) begin
              state_r <= S_LEGS;
              if (state_r == S_LEGN) begin
                ctx_r <= CX_N;
              end
            end else if (state_r == S_LEGN || (state_r == S_LEGS && ctx_r == CX_N)) begin
              ctx_r   <= CX_M;
              state_r <= S_LEGM;
            end else if (ctx_r == CX_M) begin
              ctx_r   <= CX_D;
              state_r <= S_LEGD;
            end else begin
              state_r <= S_BLKI;
            end
          end
          S_BLKI: state_r <= S_BLKC;
          S_BLKC: begin
            if (stat.i_lt_pk) begin
              state_r <= stat.j_nz ? S_BLKM : S_BLKINC;
            end else begin
              ctx_r   <= CX_N;
              state_r <= S_FFI;
            end
          end
          S_BLKM:   state_r <= S_BLKINC;
          S_BLKINC: state_r <= S_BLKC;
          S_FFI:    state_r <= S_FFC;
          S_FFC: begin
            if (!stat.x_zero) begin
              state_r <= S_FFDIV;
            end else if (ctx_r == CX_N) begin
              state_r <= S_RSET;
            end else begin
              state_r <= S_INVF;
            end
          end
          S_FFDIV: begin
            powq_r  <= 1'b0;
            state_r <= S_POWB;
          end
          S_POWB, S_POWQ: state_r <= S_POWC;
          S_POWC: begin
            if (!stat.qt_zero) begin
              state_r <= stat.qt_lsb ? S_POWA : S_POWS;
            end else begin
              state_r <= powq_r ? S_RMP : S_FFMP;
            end
          end
          S_POWA: state_r <= S_POWS;
          S_POWS: state_r <= S_POWC;
          S_FFMP: state_r <= S_FFRC;
          S_FFRC: begin
            if (stat.i_le_rm) begin
              state_r <= stat.j_nz ? S_FFMI : S_FFINC;
            end else begin
              state_r <= S_FFDQ;
            end
          end
          S_FFMI:  state_r <= S_FFINC;
          S_FFINC: state_r <= S_FFRC;
          S_FFDQ:  state_r <= S_FFC;
          S_RSET: begin
            powq_r  <= 1'b1;
            state_r <= S_POWQ;
          end
          S_RMP: begin
            ctx_r   <= CX_M;
            state_r <= S_FFI;
          end
          S_INVF: state_r <= S_INVC;
          S_INVC: state_r <= stat.g1_zero ? S_INVE : S_INVS;
          S_INVS: state_r <= S_INVC;
          S_INVE: state_r <= (ctx_r == CX_CRT) ? S_CRTW : S_RMIV;
          S_RMIV: begin
            if (ctx_r == CX_M) begin
              ctx_r   <= CX_D;
              state_r <= S_FFI;
            end else begin
              state_r <= S_CRTCO;
            end
          end
          S_CRTCO: state_r <= S_CRTM;
          S_CRTM: begin
            ctx_r   <= CX_CRT;
            state_r <= S_INVC;
          end
          S_CRTW: state_r <= S_CRTA;
          S_CRTA: begin
            if (tail_r) begin
              state_r  <= S_IDLE;
              strobe_r <= 1'b1;
            end else begin
              state_r <= S_NEXTQ;
            end
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

  assign busy       = state_r != S_IDLE;
  assign out_strobe = strobe_r;

endmodule
`default_nettype wire
